### rtl/dcbse_pkg.sv
// Package for the DC motor back-EMF speed estimator.
// Holds the sequencer state type, step counts, scaling constants and register indexes.
// No dependencies.
package dcbse_pkg;

	// sequencer states: idle, one per shared-unit operation, and done
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_CUR,
		ST_MUL_DCL,
		ST_DIV_DCL,
		ST_DIV_RAT,
		ST_MUL_VMV,
		ST_MUL_RI,
		ST_MUL_LDI,
		ST_MUL_SPD,
		ST_MUL_HC,
		ST_DIV_HC,
		ST_DONE
	} state_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_RES   = 3'd0,
		REG_LTS   = 3'd1,
		REG_GAIN  = 3'd2,
		REG_DUTY  = 3'd3,
		REG_PERIOD = 3'd4
	} reg_idx_t;

	localparam int MUL_STEPS = 16;
	localparam int DIV_STEPS = 32;
	localparam int CNT_W     = 6;

	// step count of the capture cycle of each unit
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS + 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS + 1);

	localparam logic [15:0] CUR_SCALE  = 16'd6600;
	localparam logic [15:0] DCL_SCALE  = 16'd9960;
	localparam logic [15:0] DCL_DIVSR  = 16'd4095;
	localparam logic [15:0] PCT_DIVSR  = 16'd100;
	localparam logic [6:0]  DUTY_MAX   = 7'd100;
	localparam logic [16:0] RATIO_ONE  = 17'd65536;

	localparam logic [11:0] RES_RST  = 12'd486;
	localparam logic [11:0] LTS_RST  = 12'd199;
	localparam logic [15:0] GAIN_RST = 16'd10145;

	localparam logic signed [27:0] SPD_MIN = -28'sd1048576;
	localparam logic signed [27:0] SPD_MAX = 28'sd1048575;

endpackage

### rtl/dc_motor_backemf_speed_estimator_top.sv
// Top level of the DC motor back-EMF speed estimator.
// Uses dcbse_pkg for the state type and constants; no submodules.
// Holds the sequencer, the shift-add multiplier and the restoring divider.

// One input word gives one output word. All arithmetic runs through one
// bit-serial shift-add multiplier (a load step, one step per bit of the 16-bit
// multiplier and a capture step per product) and one bit-serial restoring
// divider (a load step, one step per bit of the 32-bit dividend and a capture
// step), used seven and three times per word in turn. A new input word is taken
// once the sequencer is back to idle, even while the previous result still
// waits on the output side; a second finished result waits in the sequencer
// until the output register frees. Config writes take effect at once and belong
// in gaps with no word in flight.
module dc_motor_backemf_speed_estimator_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [2:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// current_adc[11:0], dclink_adc[23:12], pulse_high_count[39:24],
	// pulse_period_count[55:40]
	input  logic [55:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// current_ma_q4[16:0], dclink_mv[30:17], duty_ratio_q16[47:31],
	// divide_fault[48], motor_mv[62:49], wheel_speed_q8[83:63],
	// high_side_compare[99:84], low_side_compare[115:100], mid_compare[130:116], zeros
	output logic [135:0] m_axis_tdata
);

	dcbse_pkg::state_t state_q, state_d;
	logic [dcbse_pkg::CNT_W-1:0] cnt_q;
	logic op_last;
	logic op_div;

	// configuration registers
	logic [11:0] res_q, lts_q;
	logic [15:0] gain_q, period_q;
	logic [6:0]  duty_q;

	// captured input word
	logic [11:0] cadc_q, dadc_q;
	logic [15:0] hi_q, per_q;

	// intermediate results
	logic [16:0] cur_q, prev_q, ratio_q;
	logic [13:0] dcl_q;
	logic        fault_q;
	logic signed [13:0] vmv_q;
	logic [28:0] ri_q;
	logic signed [29:0] ldi_q;
	logic signed [20:0] spd_q;
	logic [15:0] hc_q;

	// shared units
	logic signed [47:0] acc_q, a_q;
	logic [15:0] b_q;
	logic [31:0] quo_q;
	logic [15:0] rem_q, dvs_q;
	logic [16:0] div_try;
	logic        div_ge;

	logic        out_vld_q;
	logic [135:0] out_q;

	// combinational helpers
	logic        vneg;
	logic [47:0] vmag, vq;
	logic signed [13:0] vmv_w;
	logic signed [47:0] e_w;
	logic signed [27:0] spd_sh;
	logic [6:0]  duty_c;
	logic [15:0] lc_w;

	// operation length and sequencing
	always_comb begin
		op_div = (state_q == dcbse_pkg::ST_DIV_DCL) || (state_q == dcbse_pkg::ST_DIV_RAT) ||
			(state_q == dcbse_pkg::ST_DIV_HC);
		op_last = op_div ? (cnt_q == dcbse_pkg::DIV_LAST) : (cnt_q == dcbse_pkg::MUL_LAST);
		state_d = state_q;
		case (state_q)
			dcbse_pkg::ST_IDLE: begin
				if (s_axis_tvalid) state_d = dcbse_pkg::ST_MUL_CUR;
			end
			dcbse_pkg::ST_MUL_CUR: if (op_last) state_d = dcbse_pkg::ST_MUL_DCL;
			dcbse_pkg::ST_MUL_DCL: if (op_last) state_d = dcbse_pkg::ST_DIV_DCL;
			dcbse_pkg::ST_DIV_DCL: if (op_last) state_d = dcbse_pkg::ST_DIV_RAT;
			dcbse_pkg::ST_DIV_RAT: if (op_last) state_d = dcbse_pkg::ST_MUL_VMV;
			dcbse_pkg::ST_MUL_VMV: if (op_last) state_d = dcbse_pkg::ST_MUL_RI;
			dcbse_pkg::ST_MUL_RI:  if (op_last) state_d = dcbse_pkg::ST_MUL_LDI;
			dcbse_pkg::ST_MUL_LDI: if (op_last) state_d = dcbse_pkg::ST_MUL_SPD;
			dcbse_pkg::ST_MUL_SPD: if (op_last) state_d = dcbse_pkg::ST_MUL_HC;
			dcbse_pkg::ST_MUL_HC:  if (op_last) state_d = dcbse_pkg::ST_DIV_HC;
			dcbse_pkg::ST_DIV_HC:  if (op_last) state_d = dcbse_pkg::ST_DONE;
			dcbse_pkg::ST_DONE: begin
				if (!out_vld_q || m_axis_tready) state_d = dcbse_pkg::ST_IDLE;
			end
			default: state_d = dcbse_pkg::ST_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == dcbse_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcbse_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dcbse_pkg::ST_IDLE || state_q == dcbse_pkg::ST_DONE || op_last)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 1'b1;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q    <= dcbse_pkg::RES_RST;
			lts_q    <= dcbse_pkg::LTS_RST;
			gain_q   <= dcbse_pkg::GAIN_RST;
			duty_q   <= '0;
			period_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				dcbse_pkg::REG_RES:    res_q    <= cfg_wdata[11:0];
				dcbse_pkg::REG_LTS:    lts_q    <= cfg_wdata[11:0];
				dcbse_pkg::REG_GAIN:   gain_q   <= cfg_wdata;
				dcbse_pkg::REG_DUTY:   duty_q   <= cfg_wdata[6:0];
				dcbse_pkg::REG_PERIOD: period_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// divider step, result shaping and error term
	always_comb begin
		div_try = {rem_q, quo_q[31]};
		div_ge = div_try >= {1'b0, dvs_q};
		vneg   = acc_q[47];
		vmag   = vneg ? 48'(-acc_q) : 48'(acc_q);
		vq     = vmag >> 16;
		vmv_w  = vneg ? -$signed(vq[13:0]) : $signed(vq[13:0]);
		e_w    = (48'(vmv_q) <<< 12) - $signed({19'b0, ri_q}) - 48'(ldi_q);
		spd_sh = 28'(acc_q >>> 20);
		duty_c = (duty_q > dcbse_pkg::DUTY_MAX) ? dcbse_pkg::DUTY_MAX : duty_q;
		lc_w   = period_q - hc_q;
	end

	// shared multiplier and divider, operand loads and result captures
	always_ff @(posedge clk) begin
		if (state_q == dcbse_pkg::ST_IDLE && s_axis_tvalid) begin
			cadc_q <= s_axis_tdata[11:0];
			dadc_q <= s_axis_tdata[23:12];
			hi_q   <= s_axis_tdata[39:24];
			per_q  <= s_axis_tdata[55:40];
		end
		if (cnt_q == '0) begin
			rem_q <= '0;
			case (state_q)
				dcbse_pkg::ST_MUL_CUR: begin
					acc_q <= '0;
					a_q <= $signed({36'b0, cadc_q});
					b_q <= dcbse_pkg::CUR_SCALE;
				end
				dcbse_pkg::ST_MUL_DCL: begin
					acc_q <= '0;
					a_q <= $signed({36'b0, dadc_q});
					b_q <= dcbse_pkg::DCL_SCALE;
				end
				dcbse_pkg::ST_DIV_DCL: begin
					quo_q <= acc_q[31:0];
					dvs_q <= dcbse_pkg::DCL_DIVSR;
				end
				dcbse_pkg::ST_DIV_RAT: begin
					quo_q <= {hi_q, 16'b0};
					dvs_q <= per_q;
				end
				dcbse_pkg::ST_MUL_VMV: begin
					acc_q <= '0;
					a_q <= $signed({31'b0, ratio_q}) - 48'sd32768;
					b_q <= {2'b0, dcl_q};
				end
				dcbse_pkg::ST_MUL_RI: begin
					acc_q <= '0;
					a_q <= $signed({31'b0, cur_q});
					b_q <= {4'b0, res_q};
				end
				dcbse_pkg::ST_MUL_LDI: begin
					acc_q <= '0;
					a_q <= $signed({31'b0, cur_q}) - $signed({31'b0, prev_q});
					b_q <= {4'b0, lts_q};
				end
				dcbse_pkg::ST_MUL_SPD: begin
					acc_q <= '0;
					a_q <= e_w;
					b_q <= gain_q;
				end
				dcbse_pkg::ST_MUL_HC: begin
					acc_q <= '0;
					a_q <= $signed({41'b0, duty_c});
					b_q <= period_q;
				end
				dcbse_pkg::ST_DIV_HC: begin
					quo_q <= acc_q[31:0];
					dvs_q <= dcbse_pkg::PCT_DIVSR;
				end
				default: ;
			endcase
		end else if (op_last) begin
			case (state_q)
				dcbse_pkg::ST_MUL_CUR: cur_q <= acc_q[24:8];
				dcbse_pkg::ST_DIV_DCL: dcl_q <= quo_q[13:0];
				dcbse_pkg::ST_DIV_RAT: begin
					fault_q <= (per_q == '0);
					if (per_q == '0)
						ratio_q <= '0;
					else if (quo_q > 32'(dcbse_pkg::RATIO_ONE))
						ratio_q <= dcbse_pkg::RATIO_ONE;
					else
						ratio_q <= quo_q[16:0];
				end
				dcbse_pkg::ST_MUL_VMV: vmv_q <= vmv_w;
				dcbse_pkg::ST_MUL_RI:  ri_q  <= acc_q[28:0];
				dcbse_pkg::ST_MUL_LDI: ldi_q <= acc_q[29:0];
				dcbse_pkg::ST_MUL_SPD: begin
					if (spd_sh < dcbse_pkg::SPD_MIN)
						spd_q <= 21'(dcbse_pkg::SPD_MIN);
					else if (spd_sh > dcbse_pkg::SPD_MAX)
						spd_q <= 21'(dcbse_pkg::SPD_MAX);
					else
						spd_q <= spd_sh[20:0];
				end
				dcbse_pkg::ST_DIV_HC: hc_q <= quo_q[15:0];
				default: ;
			endcase
		end else if (op_div) begin
			// restoring divide, one quotient bit a cycle
			rem_q <= div_ge ? 16'(div_try - {1'b0, dvs_q}) : div_try[15:0];
			quo_q <= {quo_q[30:0], div_ge};
		end else begin
			// shift-add multiply, one multiplier bit a cycle
			if (b_q[0]) acc_q <= acc_q + a_q;
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
		if (state_q == dcbse_pkg::ST_DONE && (!out_vld_q || m_axis_tready)) begin
			out_q <= {5'b0, period_q[15:1], lc_w, hc_q, spd_q, vmv_q, fault_q, ratio_q,
				dcl_q, cur_q};
		end
	end

	// output valid and current history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			prev_q    <= '0;
		end else begin
			if (state_q == dcbse_pkg::ST_DONE && (!out_vld_q || m_axis_tready)) begin
				out_vld_q <= 1'b1;
				prev_q    <= cur_q;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

	// a fault word never carries a nonzero ratio
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[48] |-> m_axis_tdata[47:31] == '0)
		else $error("fault word with nonzero duty ratio");

	// an accepted word starts the sequence
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q == dcbse_pkg::ST_MUL_CUR && cnt_q == '0)
		else $error("sequencer did not start on accepted word");

	// step counter stays within the longest operation
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= dcbse_pkg::DIV_LAST)
		else $error("step counter overran");

endmodule

### verif/dc_motor_backemf_speed_estimator_top_test.sv
// Testbench for the DC motor back-EMF speed estimator top level.
// Depends on dcbse_pkg and dc_motor_backemf_speed_estimator_top; drives words, checks results.
module dc_motor_backemf_speed_estimator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	// one decoded result word
	typedef struct packed {
		logic [14:0] mid;
		logic [15:0] lcmp;
		logic [15:0] hcmp;
		logic [20:0] speed;
		logic [13:0] vmv;
		logic        fault;
		logic [16:0] ratio;
		logic [13:0] dcl;
		logic [16:0] cur;
	} est_t;

	// directed stimulus row; has_exp marks rows with a typed-in result
	typedef struct {
		logic [11:0] cadc;
		logic [11:0] dadc;
		logic [15:0] hi;
		logic [15:0] per;
		bit          has_exp;
		est_t        exp_word;
	} row_t;

	localparam int TIMEOUT_CYCLES = 2000000;
	localparam int N_RANDOM = 1100;
	localparam int SETTLE = 300;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [2:0]   cfg_addr = '0;
	logic [15:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [55:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [135:0] m_axis_tdata;

	dc_motor_backemf_speed_estimator_top uut (.*);

	always #5 clk = ~clk;

	// predictor state and configuration copy
	logic [11:0] res_q8, lts_q8;
	logic [15:0] gain_q16, period_cnt;
	logic [6:0]  duty_pct;
	logic [16:0] last_cur;

	est_t pending_results[$];
	int   fail_count = 0;
	int   cycle_count = 0;
	bit   idle_on = 1'b1;
	bit   rx_hold = 1'b0;
	bit   stim_done = 1'b0;

	function automatic est_t estimate(input logic [11:0] cadc, input logic [11:0] dadc,
			input logic [15:0] hi, input logic [15:0] per);
		est_t r;
		longint cur, dcl, ratio, vnum, vmv, e, spd, duty, hc, q;
		cur = (longint'(cadc) * 6600) >>> 8;
		dcl = (longint'(dadc) * 9960) / 4095;
		ratio = 0;
		if (per != 0) begin
			q = (longint'(hi) << 16) / longint'(per);
			ratio = q > 65536 ? 65536 : q;
		end
		vnum = dcl * (ratio - 32768);
		vmv = vnum >= 0 ? vnum / 65536 : -((-vnum) / 65536);
		e = vmv * 4096 - longint'(res_q8) * cur - longint'(lts_q8) * (cur - longint'(last_cur));
		// arithmetic shift is a floor division by 2^20
		spd = (e * longint'(gain_q16)) >>> 20;
		if (spd < -1048576) spd = -1048576;
		if (spd > 1048575) spd = 1048575;
		duty = duty_pct > 100 ? 100 : duty_pct;
		hc = (duty * longint'(period_cnt)) / 100;
		r.cur = cur[16:0];
		r.dcl = dcl[13:0];
		r.ratio = ratio[16:0];
		r.fault = (per == 0);
		r.vmv = vmv[13:0];
		r.speed = spd[20:0];
		r.hcmp = hc[15:0];
		r.lcmp = 16'(longint'(period_cnt) - hc);
		r.mid = period_cnt[15:1];
		return r;
	endfunction

	// register write at one rising edge, mirrored into the predictor
	task automatic write_reg(input dcbse_pkg::reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			dcbse_pkg::REG_RES:    res_q8 = val[11:0];
			dcbse_pkg::REG_LTS:    lts_q8 = val[11:0];
			dcbse_pkg::REG_GAIN:   gain_q16 = val;
			dcbse_pkg::REG_DUTY:   duty_pct = val[6:0];
			dcbse_pkg::REG_PERIOD: period_cnt = val;
			default: ;
		endcase
	endtask

	task automatic set_all(input logic [11:0] r, input logic [11:0] l, input logic [15:0] g,
			input logic [6:0] d, input logic [15:0] p);
		write_reg(dcbse_pkg::REG_RES, 16'(r));
		write_reg(dcbse_pkg::REG_LTS, 16'(l));
		write_reg(dcbse_pkg::REG_GAIN, g);
		write_reg(dcbse_pkg::REG_DUTY, 16'(d));
		write_reg(dcbse_pkg::REG_PERIOD, p);
	endtask

	// stop offering, wait until all results are in, then let the block settle
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// offer one word at the falling edge and hold it until accepted
	task automatic send_word(input logic [11:0] cadc, input logic [11:0] dadc,
			input logic [15:0] hi, input logic [15:0] per, input bit has_exp, input est_t ex);
		est_t pred;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {per, hi, dadc, cadc};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pred = estimate(cadc, dadc, hi, per);
		last_cur = pred.cur;
		if (has_exp && ex != pred) begin
			$error("typed-in result differs from predictor: %h vs %h", ex, pred);
			fail_count++;
		end
		pending_results.push_back(has_exp ? ex : pred);
		@(negedge clk);
	endtask

	// receiver: random backpressure, plus a long hold-off on request
	always @(negedge clk) begin
		if (rx_hold)
			m_axis_tready <= 1'b0;
		else if (idle_on && $urandom_range(0, 7) == 0)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= 1'b1;
	end

	// result checking against the oldest expectation
	always @(posedge clk) begin
		est_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = est_t'(m_axis_tdata[130:0]);
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (got.cur !== want.cur) begin
					$error("current_ma_q4 exp %0d got %0d", want.cur, got.cur); fail_count++;
				end
				if (got.dcl !== want.dcl) begin
					$error("dclink_mv exp %0d got %0d", want.dcl, got.dcl); fail_count++;
				end
				if (got.ratio !== want.ratio) begin
					$error("duty_ratio_q16 exp %0d got %0d", want.ratio, got.ratio); fail_count++;
				end
				if (got.fault !== want.fault) begin
					$error("divide_fault exp %0d got %0d", want.fault, got.fault); fail_count++;
				end
				if (got.vmv !== want.vmv) begin
					$error("motor_mv exp %0d got %0d", $signed(want.vmv), $signed(got.vmv));
					fail_count++;
				end
				if (got.speed !== want.speed) begin
					$error("wheel_speed_q8 exp %0d got %0d", $signed(want.speed),
						$signed(got.speed));
					fail_count++;
				end
				if (got.hcmp !== want.hcmp) begin
					$error("high_side_compare exp %0d got %0d", want.hcmp, got.hcmp); fail_count++;
				end
				if (got.lcmp !== want.lcmp) begin
					$error("low_side_compare exp %0d got %0d", want.lcmp, got.lcmp); fail_count++;
				end
				if (got.mid !== want.mid) begin
					$error("mid_compare exp %0d got %0d", want.mid, got.mid); fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	// long receiver hold-off while the sender keeps offering words
	initial begin
		wait (stim_done == 1'b0 && cycle_count > 20000);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (3000) @(negedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		row_t rows[$];
		row_t rw;
		est_t zero_word;
		int cfg_phase;
		logic [11:0] ca, da;
		logic [15:0] hi, per;
		int k;
		res_q8 = dcbse_pkg::RES_RST; lts_q8 = dcbse_pkg::LTS_RST; gain_q16 = dcbse_pkg::GAIN_RST;
		duty_pct = '0; period_cnt = '0; last_cur = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// after reset, all-zero input: zero current, zero link, fault, compares zero
		zero_word = '0;
		zero_word.fault = 1'b1;
		rows.push_back('{12'd0, 12'd0, 16'd0, 16'd0, 1'b1, zero_word});
		// extremes, zero period, high time above period, equal counts
		rows.push_back('{12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 1'b0, zero_word});
		rows.push_back('{12'hFFF, 12'hFFF, 16'd0, 16'hFFFF, 1'b0, zero_word});
		rows.push_back('{12'd0, 12'hFFF, 16'hFFFF, 16'd0, 1'b0, zero_word});
		rows.push_back('{12'd0, 12'hFFF, 16'hFFFF, 16'd1, 1'b0, zero_word});
		rows.push_back('{12'hFFF, 12'd0, 16'd500, 16'd1000, 1'b0, zero_word});
		rows.push_back('{12'd0, 12'd2048, 16'd1, 16'd3, 1'b0, zero_word});
		rows.push_back('{12'd1234, 12'd3000, 16'd700, 16'd1000, 1'b0, zero_word});
		foreach (rows[i]) begin
			rw = rows[i];
			send_word(rw.cadc, rw.dadc, rw.hi, rw.per, rw.has_exp, rw.exp_word);
		end
		drain();

		// extreme settings: speed saturation both ways, duty above one hundred
		set_all(12'hFFF, 12'hFFF, 16'hFFFF, 7'd127, 16'hFFFF);
		send_word(12'hFFF, 12'd0, 16'd0, 16'd1, 1'b0, zero_word);
		send_word(12'd0, 12'hFFF, 16'd1, 16'd1, 1'b0, zero_word);
		send_word(12'd0, 12'hFFF, 16'hFFFF, 16'd2, 1'b0, zero_word);
		drain();
		set_all(12'd0, 12'd0, 16'd0, 7'd100, 16'd1);
		send_word(12'hFFF, 12'hFFF, 16'd3, 16'd7, 1'b0, zero_word);
		drain();

		// random phases with random and extreme settings
		for (cfg_phase = 0; cfg_phase < 11; cfg_phase++) begin
			if (cfg_phase == 9) idle_on = 1'b0;
			if (cfg_phase % 3 == 0)
				set_all(12'($urandom), 12'($urandom), 16'($urandom),
					7'($urandom), 16'($urandom));
			else
				set_all(12'($urandom_range(0, 1000)), 12'($urandom_range(0, 600)),
					16'($urandom_range(0, 30000)), 7'($urandom_range(0, 100)),
					16'($urandom));
			for (k = 0; k < N_RANDOM / 11; k++) begin
				ca = 12'($urandom);
				da = 12'($urandom);
				per = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
				case ($urandom_range(0, 3))
					0: hi = 16'($urandom);
					1: hi = per;
					default: hi = 16'($urandom_range(0, per));
				endcase
				send_word(ca, da, hi, per, 1'b0, zero_word);
			end
			drain();
		end
		stim_done = 1'b1;

		if (fail_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
